### sv/oks_pkg.sv
package oks_pkg;

    // defaults for the top level parameters
    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_KEY_WIDTH = 32;

    // fixed widths of the request and result ports
    localparam int ACTION_W = 3;
    localparam int IO_KEY_W = 32;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_EXISTS = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_NEXT   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PREV   = 3'd4;

    // row operations broadcast to every cell
    localparam int CELL_OP_W = 2;
    localparam logic [CELL_OP_W-1:0] CELL_HOLD   = 2'd0;
    localparam logic [CELL_OP_W-1:0] CELL_INSERT = 2'd1;
    localparam logic [CELL_OP_W-1:0] CELL_DELETE = 2'd2;

    typedef struct packed {
        logic                 cmp_en;
        logic [CELL_OP_W-1:0] op;
    } cell_ctrl_t;

    // compare result of one cell against the request key
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } cell_flag_t;

endpackage

### sv/oks_cell.sv
module oks_cell
    import oks_pkg::*;
#(
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctrl_t           ctrl,
    input  logic [KEY_WIDTH-1:0] cmp_key,
    input  logic [KEY_WIDTH-1:0] left_key,
    input  logic                 left_valid,
    input  cell_flag_t           left_flag,
    input  logic [KEY_WIDTH-1:0] right_key,
    input  logic                 right_valid,
    output logic [KEY_WIDTH-1:0] key,
    output logic                 valid,
    output cell_flag_t           flag
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 valid_reg;
    logic                 valid_next;
    cell_flag_t           flag_reg;
    cell_flag_t           flag_next;
    logic                 less;
    logic                 same;

    assign less = $signed(key_reg) < $signed(cmp_key);
    assign same = key_reg == cmp_key;

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        flag_next  = flag_reg;
        if (ctrl.cmp_en)
        begin
            flag_next.lt = valid_reg & less;
            flag_next.eq = valid_reg & same;
            flag_next.gt = valid_reg & ~less & ~same;
        end
        unique case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_INSERT:
            begin
                // cells at or above the insert point move up by one
                if (!flag_reg.lt)
                begin
                    if (left_flag.lt)
                    begin
                        key_next   = cmp_key;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        key_next   = left_key;
                        valid_next = left_valid;
                    end
                end
            end
            CELL_DELETE:
            begin
                // cells from the removed slot upward close the gap
                if (!flag_reg.lt)
                begin
                    key_next   = right_key;
                    valid_next = right_valid;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flag_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;
    assign flag  = flag_reg;

endmodule

### sv/ordered_key_set.sv
// Ordered set of distinct signed keys held in a sorted row of CAPACITY cells.
// Each request (insert, delete, exists, next greater, previous smaller) is
// taken when start is high and busy is low, and gives exactly one result:
// done is high for one cycle with hit, neighbour and full_res valid. The
// receiver cannot stall, so the result must be captured in that cycle.
// done comes from a register loaded in the update state, and busy drops in
// the cycle in which done rises, so a new item can be taken at the edge that
// ends it; no new item is taken before done. The steps are set by the cell
// row and the result register: every cell registers its compare against the
// request key, then the row shifts (insert or delete) while the found
// neighbour is picked from the flags and registered, and the registered
// result is then shown.
// Reset empties the set at once; no clearing pass is needed.
module ordered_key_set
    import oks_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [ACTION_W-1:0] action,
    input  logic [IO_KEY_W-1:0] key,
    output logic                done,
    output logic                hit,
    output logic [IO_KEY_W-1:0] neighbour,
    output logic                full_res
);

    // sequencer: idle, cells compare, row shifts and result is built
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
    localparam logic [ST_W-1:0] ST_CMP  = 2'd1;
    localparam logic [ST_W-1:0] ST_UPD  = 2'd2;

    logic [ST_W-1:0]      state_reg;
    logic [ST_W-1:0]      state_next;

    logic [ACTION_W-1:0]  act_reg;
    logic [KEY_WIDTH-1:0] req_key_reg;
    logic [KEY_WIDTH-1:0] key_ext;
    logic                 accept;

    logic                 done_reg;
    logic                 hit_reg;
    logic                 hit_next;
    logic                 full_res_reg;
    logic                 full_res_next;
    logic [KEY_WIDTH-1:0] nb_reg;
    logic [KEY_WIDTH-1:0] nb_next;

    cell_ctrl_t           ctrl;

    // per cell view of the row
    logic [KEY_WIDTH-1:0] cell_key   [CAPACITY];
    logic                 cell_valid [CAPACITY];
    cell_flag_t           cell_flag  [CAPACITY];
    logic [CAPACITY-1:0]  succ_sel;
    logic [CAPACITY-1:0]  pred_sel;
    logic [CAPACITY-1:0]  eq_vec;

    logic                 present;
    logic                 is_full;
    logic                 succ_any;
    logic                 pred_any;
    logic [KEY_WIDTH-1:0] succ_key;
    logic [KEY_WIDTH-1:0] pred_key;

    assign accept = start & ~busy;
    assign busy   = state_reg != ST_IDLE;

    // request key brought to the stored width: sign extend when wider, keep low bits when narrower
    generate
        if (KEY_WIDTH <= IO_KEY_W)
        begin : g_key_narrow
            assign key_ext = key[KEY_WIDTH-1:0];
        end
        else
        begin : g_key_wide
            assign key_ext = {{(KEY_WIDTH-IO_KEY_W){key[IO_KEY_W-1]}}, key};
        end
    endgenerate

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:  state_next = accept ? ST_CMP : ST_IDLE;
            ST_CMP:   state_next = ST_UPD;
            ST_UPD:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg     <= action;
            req_key_reg <= key_ext;
        end
    end

    // the row is kept as a prefix of valid cells, so it is full when the
    // top cell holds a key
    assign is_full = cell_valid[CAPACITY-1];

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            eq_vec[i] = cell_flag[i].eq;
        end
    end

    assign present = |eq_vec;

    // successor is the lowest cell above the key, predecessor the highest
    // cell below it; both are single cells thanks to the sorted order
    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_sel
            if (i == 0)
            begin : g_first
                assign succ_sel[i] = cell_flag[i].gt;
            end
            else
            begin : g_rest
                assign succ_sel[i] = cell_flag[i].gt & ~cell_flag[i-1].gt;
            end
            if (i == CAPACITY-1)
            begin : g_last
                assign pred_sel[i] = cell_flag[i].lt;
            end
            else
            begin : g_inner
                assign pred_sel[i] = cell_flag[i].lt & ~cell_flag[i+1].lt;
            end
        end
    endgenerate

    assign succ_any = |succ_sel;
    assign pred_any = |pred_sel;

    // one-hot select: or together the masked keys
    always_comb
    begin
        succ_key = '0;
        pred_key = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            succ_key = succ_key | (cell_key[i] & {KEY_WIDTH{succ_sel[i]}});
            pred_key = pred_key | (cell_key[i] & {KEY_WIDTH{pred_sel[i]}});
        end
    end

    // row control for the compare and update cycles, and result for the update cycle
    always_comb
    begin
        ctrl.cmp_en   = state_reg == ST_CMP;
        ctrl.op       = CELL_HOLD;
        hit_next      = 1'b0;
        full_res_next = 1'b0;
        nb_next       = '0;
        if (state_reg == ST_UPD)
        begin
            unique case (act_reg)
                ACT_INSERT:
                begin
                    // duplicate is ignored, even when full
                    if (!present)
                    begin
                        if (is_full)
                        begin
                            full_res_next = 1'b1;
                        end
                        else
                        begin
                            ctrl.op  = CELL_INSERT;
                            hit_next = 1'b1;
                        end
                    end
                end
                ACT_DELETE:
                begin
                    if (present)
                    begin
                        ctrl.op  = CELL_DELETE;
                        hit_next = 1'b1;
                    end
                end
                ACT_EXISTS:
                begin
                    hit_next = present;
                end
                ACT_NEXT:
                begin
                    hit_next = succ_any;
                    nb_next  = succ_key;
                end
                ACT_PREV:
                begin
                    hit_next = pred_any;
                    nb_next  = pred_key;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            full_res_reg <= 1'b0;
        end
        else
        begin
            done_reg     <= state_reg == ST_UPD;
            hit_reg      <= hit_next;
            full_res_reg <= full_res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nb_reg <= nb_next;
    end

    // the cell row; the ends see an empty neighbor, and the bottom cell sees
    // a left neighbor that is below every key
    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [KEY_WIDTH-1:0] left_key;
            logic                 left_valid;
            cell_flag_t           left_flag;
            logic [KEY_WIDTH-1:0] right_key;
            logic                 right_valid;

            if (i == 0)
            begin : g_left_edge
                assign left_key   = '0;
                assign left_valid = 1'b0;
                assign left_flag  = '{lt: 1'b1, eq: 1'b0, gt: 1'b0};
            end
            else
            begin : g_left
                assign left_key   = cell_key[i-1];
                assign left_valid = cell_valid[i-1];
                assign left_flag  = cell_flag[i-1];
            end

            if (i == CAPACITY-1)
            begin : g_right_edge
                assign right_key   = '0;
                assign right_valid = 1'b0;
            end
            else
            begin : g_right
                assign right_key   = cell_key[i+1];
                assign right_valid = cell_valid[i+1];
            end

            oks_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .cmp_key     (req_key_reg),
                .left_key    (left_key),
                .left_valid  (left_valid),
                .left_flag   (left_flag),
                .right_key   (right_key),
                .right_valid (right_valid),
                .key         (cell_key[i]),
                .valid       (cell_valid[i]),
                .flag        (cell_flag[i])
            );
        end
    endgenerate

    // found key goes out in its low bits, zero filled when narrower
    generate
        if (KEY_WIDTH >= IO_KEY_W)
        begin : g_nb_wide
            assign neighbour = nb_reg[IO_KEY_W-1:0];
        end
        else
        begin : g_nb_narrow
            assign neighbour = {{(IO_KEY_W-KEY_WIDTH){1'b0}}, nb_reg};
        end
    endgenerate

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign full_res = full_res_reg;

endmodule
